// File: sv/tcpg_pkg.sv
package tcpg_pkg;

	// Default tick rate of the time base.
	localparam int unsigned TPS_DEFAULT = 1000000;

	// Configuration register fields.
	localparam int FREQ_W = 20;
	localparam int DUTY_W = 16;
	localparam int CFG_W = FREQ_W;
	localparam int CFG_IDX_W = 2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FREQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY = 2'd1;

	// Frequency is Q.4 Hz; anything below 1 Hz runs at 1 Hz.
	localparam logic [FREQ_W-1:0] FREQ_RESET = 20'd16000;
	localparam logic [FREQ_W-1:0] FREQ_MIN = 20'd16;
	localparam int FREQ_FRAC = 4;

	// Duty is Q2.14; after saturation it fits 15 unsigned bits.
	localparam int DSAT_W = 15;
	localparam int DUTY_FRAC = 14;
	localparam logic [DSAT_W-1:0] DUTY_FULL = 15'd16384;
	localparam logic [DSAT_W-1:0] DUTY_HI = 15'd16220;
	localparam logic [DSAT_W-1:0] DUTY_LO = 15'd164;

	// Commands from the controller to the timing calculator.
	typedef struct packed {
		logic div_init;
		logic div_step;
		logic mul_en;
		logic load_en;
	} calc_cmd_t;

	// Status from the timing calculator to the controller.
	typedef struct packed {
		logic cfg_hit;
	} calc_stat_t;

endpackage

// File: sv/tcpg_ctrl.sv
module tcpg_ctrl #(
	parameter int DIV_W = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tcpg_pkg::calc_stat_t  stat,
	output tcpg_pkg::calc_cmd_t   cmd,
	output logic                  idle
);
	import tcpg_pkg::*;

	localparam int CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INIT = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_LOAD = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;

	// Sequence: clear the divider, one quotient bit per cycle, multiply, load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (stat.cfg_hit) state_q <= ST_INIT;
				end
				ST_INIT: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command decode.
	always_comb begin
		cmd.div_init = (state_q == ST_INIT);
		cmd.div_step = (state_q == ST_DIV);
		cmd.mul_en = (state_q == ST_MUL);
		cmd.load_en = (state_q == ST_LOAD);
		idle = (state_q == ST_IDLE);
	end

endmodule

// File: sv/tcpg_calc.sv
module tcpg_calc #(
	parameter int unsigned TICKS_PER_SECOND = 1000000,
	parameter int PERIOD_W = 20,
	parameter int DIV_W = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_fire,
	input  logic [tcpg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tcpg_pkg::CFG_W-1:0]        cfg_data,
	input  tcpg_pkg::calc_cmd_t               cmd,
	output tcpg_pkg::calc_stat_t              stat,
	output logic [PERIOD_W-1:0]               high_ticks,
	output logic [PERIOD_W-1:0]               low_ticks
);
	import tcpg_pkg::*;

	localparam int PROD_W = PERIOD_W + DSAT_W;
	localparam logic [DIV_W-1:0] DIVIDEND =
		DIV_W'(64'(TICKS_PER_SECOND) * 64'(2 ** FREQ_FRAC));
	localparam logic [PERIOD_W-1:0] RST_PERIOD =
		PERIOD_W'(64'(TICKS_PER_SECOND) * 64'(2 ** FREQ_FRAC) / 64'(FREQ_RESET));

	logic [FREQ_W-1:0]        freq_q;
	logic signed [DUTY_W-1:0] duty_q;
	logic [DIV_W-1:0]         dvd_q;
	logic [DIV_W-1:0]         quo_q;
	logic [FREQ_W-1:0]        rem_q;
	logic [PROD_W-1:0]        prod_q;
	logic [PERIOD_W-1:0]      high_q;
	logic [PERIOD_W-1:0]      low_q;

	logic [FREQ_W-1:0]   freq_eff;
	logic [FREQ_W:0]     trial;
	logic [FREQ_W:0]     diff;
	logic                fits;
	logic [PERIOD_W-1:0] period;
	logic [DSAT_W-1:0]   duty_sat;
	logic [PERIOD_W-1:0] high_part;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FREQ_RESET;
			duty_q <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				REG_FREQ: freq_q <= cfg_data[FREQ_W-1:0];
				REG_DUTY: duty_q <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	assign stat.cfg_hit = cfg_fire && (cfg_index == REG_FREQ || cfg_index == REG_DUTY);

	// Restoring divider: one quotient bit of ticks/frequency per step.
	assign freq_eff = (freq_q < FREQ_MIN) ? FREQ_MIN : freq_q;
	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign diff = trial - {1'b0, freq_eff};
	assign fits = (trial >= {1'b0, freq_eff});

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dvd_q <= DIVIDEND;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			rem_q <= fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	// The quotient never exceeds the tick rate, so its top bits are zero.
	assign period = quo_q[PERIOD_W-1:0];

	// Duty saturated to 0..1.0.
	always_comb begin
		if (duty_q[DUTY_W-1]) begin
			duty_sat = '0;
		end else if (duty_q[DUTY_W-2:0] > DUTY_FULL) begin
			duty_sat = DUTY_FULL;
		end else begin
			duty_sat = duty_q[DSAT_W-1:0];
		end
	end

	// Period times duty, registered.
	always_ff @(posedge clk) begin
		if (cmd.mul_en) prod_q <= PROD_W'(period) * PROD_W'(duty_sat);
	end

	assign high_part = prod_q[PROD_W-2:DUTY_FRAC];

	// Phase lengths, with snapping near fully high and fully low.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= '0;
			low_q <= RST_PERIOD;
		end else if (cmd.load_en) begin
			if (duty_sat > DUTY_HI) begin
				high_q <= period;
				low_q <= '0;
			end else if (duty_sat < DUTY_LO) begin
				high_q <= '0;
				low_q <= period;
			end else begin
				high_q <= high_part;
				low_q <= period - high_part;
			end
		end
	end

	assign high_ticks = high_q;
	assign low_ticks = low_q;

endmodule

// File: sv/tcpg_phase.sv
module tcpg_phase #(
	parameter int unsigned TICKS_PER_SECOND = 1000000,
	parameter int PERIOD_W = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                busy,
	input  logic [PERIOD_W-1:0] high_ticks,
	input  logic [PERIOD_W-1:0] low_ticks,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                run,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                pin_level,
	output logic                rising_edge,
	output logic                falling_edge
);
	import tcpg_pkg::*;

	localparam logic [PERIOD_W-1:0] RST_PERIOD =
		PERIOD_W'(64'(TICKS_PER_SECOND) * 64'(2 ** FREQ_FRAC) / 64'(FREQ_RESET));

	logic [PERIOD_W-1:0] rem_q;
	logic                level_q;
	logic                out_valid_q;
	logic                rise_q;
	logic                fall_q;

	logic                accept;
	logic [PERIOD_W-1:0] rem_nxt;
	logic                level_nxt;

	// A new tick is taken when no recompute is busy and the result register is free or being emptied.
	assign in_stall = busy || (out_valid_q && out_stall);
	assign accept = in_valid && !in_stall;

	// Phase counter: run low restarts the low phase; else reload at phase end, skipping a zero-length phase.
	always_comb begin
		rem_nxt = rem_q - 1'b1;
		level_nxt = level_q;
		if (!run) begin
			level_nxt = 1'b0;
			rem_nxt = low_ticks;
		end else if (rem_q <= PERIOD_W'(1)) begin
			if (!level_q) begin
				if (high_ticks == '0) begin
					rem_nxt = low_ticks;
				end else begin
					level_nxt = 1'b1;
					rem_nxt = high_ticks;
				end
			end else begin
				if (low_ticks == '0) begin
					rem_nxt = high_ticks;
				end else begin
					level_nxt = 1'b0;
					rem_nxt = low_ticks;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= RST_PERIOD;
			level_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (accept) begin
			rem_q <= rem_nxt;
			level_q <= level_nxt;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Edge flags of the result held for transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			rise_q <= !level_q && level_nxt;
			fall_q <= level_q && !level_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign pin_level = level_q;
	assign rising_edge = rise_q;
	assign falling_edge = fall_q;

endmodule

// File: sv/tick_counting_pwm_generator.sv
// Tick-driven PWM generator. Every accepted input item with run high is one
// time tick; the pin spends low_ticks ticks low and then high_ticks ticks
// high, and run low restarts it at the start of the low phase. Ticks are
// taken one per clock cycle unless a recompute or a stalled output holds
// them off, and a result stays in an output register until transferred. A
// configuration write to the frequency or duty register recomputes the
// phase lengths with a bit-serial divider of DIV_W bits, the bit width of
// TICKS_PER_SECOND * 16, and one multiply; the port and the tick input are
// held off until that is done. The phase already counting finishes with its
// old length; new lengths apply at the next reload.
module tick_counting_pwm_generator #(
	parameter int unsigned TICKS_PER_SECOND = tcpg_pkg::TPS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           run,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           pin_level,
	output logic                           rising_edge,
	output logic                           falling_edge,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tcpg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tcpg_pkg::CFG_W-1:0]     cfg_data
);
	import tcpg_pkg::*;

	localparam int PERIOD_W = $clog2(TICKS_PER_SECOND + 1);
	localparam int DIV_W = PERIOD_W + FREQ_FRAC;

	calc_cmd_t           cmd;
	calc_stat_t          stat;
	logic                idle;
	logic                cfg_fire;
	logic [PERIOD_W-1:0] high_ticks;
	logic [PERIOD_W-1:0] low_ticks;

	assign cfg_ready = idle;
	assign cfg_fire = cfg_valid && cfg_ready;

	tcpg_ctrl #(
		.DIV_W(DIV_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.stat(stat),
		.cmd(cmd),
		.idle(idle)
	);

	tcpg_calc #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND),
		.PERIOD_W(PERIOD_W),
		.DIV_W(DIV_W)
	) u_calc (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_fire(cfg_fire),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.stat(stat),
		.high_ticks(high_ticks),
		.low_ticks(low_ticks)
	);

	tcpg_phase #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND),
		.PERIOD_W(PERIOD_W)
	) u_phase (
		.clk(clk),
		.arst_n(arst_n),
		.busy(!idle),
		.high_ticks(high_ticks),
		.low_ticks(low_ticks),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.run(run),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pin_level(pin_level),
		.rising_edge(rising_edge),
		.falling_edge(falling_edge)
	);

endmodule

// File: sv/tcpg_checker.sv
module tcpg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic run,
	input logic out_valid,
	input logic out_stall,
	input logic pin_level,
	input logic rising_edge,
	input logic falling_edge,
	input logic cfg_ready
);

	// An edge flag always agrees with the level it reports.
	a_edge_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((!rising_edge || pin_level) && (!falling_edge || !pin_level)))
		else $error("edge flag disagrees with pin level");

	// While the phase lengths are recomputed, no tick is taken.
	a_recalc_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> in_stall)
		else $error("tick accepted during recompute");

	// A restart leaves the pin low with no rising edge.
	a_restart_low: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !run) |=> (out_valid && !pin_level && !rising_edge))
		else $error("restart did not leave pin low");

	// A result held back by the receiver stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(pin_level) && $stable(rising_edge) && $stable(falling_edge)))
		else $error("stalled result changed");

endmodule

bind tick_counting_pwm_generator tcpg_checker u_tcpg_checker (.*);
